### rtl/uvc_pkg.sv
`default_nettype none

package uvc_pkg;

  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned COUNT_W    = 4;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic {
    ST_OK       = 1'b0,
    ST_OVERFLOW = 1'b1
  } status_e;

  typedef struct packed {
    logic                 fire;
    logic [BYTE_BITS-1:0] data;
    logic                 last;
  } enc_out_t;

  typedef struct packed {
    logic               fire;
    logic [COUNT_W-1:0] count;
    status_e            status;
  } dec_stat_t;

endpackage

`default_nettype wire

### rtl/uvc_in_if.sv
`default_nettype none

interface uvc_in_if #(
  parameter int unsigned VW = 64
) ();
  logic          valid;
  logic          ready;
  logic          opcode;
  logic [VW-1:0] in_value;
  logic [7:0]    in_byte;

  modport source (output valid, output opcode, output in_value, output in_byte, input ready);
  modport sink   (input valid, input opcode, input in_value, input in_byte, output ready);
endinterface

`default_nettype wire

### rtl/uvc_out_if.sv
`default_nettype none

interface uvc_out_if #(
  parameter int unsigned VW = 64
) ();
  logic          valid;
  logic          ready;
  logic [7:0]    out_byte;
  logic [VW-1:0] out_value;
  logic [3:0]    byte_count;
  logic          status;
  logic          last;

  modport source (output valid, output out_byte, output out_value, output byte_count,
                  output status, output last, input ready);
  modport sink   (input valid, input out_byte, input out_value, input byte_count,
                  input status, input last, output ready);
endinterface

`default_nettype wire

### rtl/uvarint_codec.sv
// channel  dir  payload                                           request
// req_i    in   opcode, in_value[VW-1:0], in_byte[7:0]            valid & ready
// rsp_o    out  out_byte, out_value[VW-1:0], byte_count, status,  valid & ready
//               last
// Decode: one byte per cycle unless stalled, result registered as the byte is taken.
// Encode: n = ceil(bits/7) bytes (1 min), one per cycle unless stalled, 7 bits
//   shifted out of a VW-bit register per byte; req_i is blocked until the last byte.
// Back-pressure on rsp_o stalls the shifter and holds req_i ready low.
// rst_ni clears decoder state, shifter busy flag and output valid.
`default_nettype none

module uvarint_codec
  import uvc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  uvc_in_if.sink    req_i,
  uvc_out_if.source rsp_o
);

  logic                   slot_free;
  logic                   accept;
  logic                   enc_busy;
  enc_out_t               enc;
  dec_stat_t              dec;
  logic [VALUE_WIDTH-1:0] dec_value;

  logic                   valid_q;
  logic [BYTE_BITS-1:0]   byte_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [COUNT_W-1:0]     count_q;
  logic                   status_q;
  logic                   last_q;

  assign slot_free   = !valid_q || rsp_o.ready;
  assign req_i.ready = !enc_busy && slot_free;
  assign accept      = req_i.valid && req_i.ready;

  uvc_encoder #(.VW(VALUE_WIDTH)) u_enc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept && (req_i.opcode == OP_ENCODE)),
    .step_i  (slot_free),
    .value_i (req_i.in_value),
    .enc_o   (enc),
    .busy_o  (enc_busy)
  );

  uvc_decoder #(.VW(VALUE_WIDTH)) u_dec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (accept && (req_i.opcode == OP_DECODE)),
    .byte_i  (req_i.in_byte),
    .stat_o  (dec),
    .value_o (dec_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (slot_free) begin
      valid_q <= enc.fire || dec.fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc.fire) begin
      byte_q   <= enc.data;
      value_q  <= '0;
      count_q  <= '0;
      status_q <= ST_OK;
      last_q   <= enc.last;
    end else if (dec.fire) begin
      byte_q   <= '0;
      value_q  <= dec_value;
      count_q  <= dec.count;
      status_q <= dec.status;
      last_q   <= 1'b1;
    end
  end

  assign rsp_o.valid      = valid_q;
  assign rsp_o.out_byte   = byte_q;
  assign rsp_o.out_value  = value_q;
  assign rsp_o.byte_count = count_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.last       = last_q;

endmodule

`default_nettype wire

### rtl/uvc_encoder.sv
`default_nettype none

module uvc_encoder
  import uvc_pkg::*;
#(
  parameter int unsigned VW = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire logic          step_i,
  input  wire logic [VW-1:0] value_i,
  output enc_out_t           enc_o,
  output logic               busy_o
);

  logic          busy_q, busy_d;
  logic [VW-1:0] shr_q, shr_d;
  logic [VW-1:0] cur;
  logic [VW-1:0] rest;
  logic          emit;

  assign cur  = busy_q ? shr_q : value_i;
  assign rest = cur >> GROUP_BITS;
  assign emit = load_i | (busy_q & step_i);

  assign enc_o.fire = emit;
  assign enc_o.last = (rest == '0);
  assign enc_o.data = {(rest != '0), cur[GROUP_BITS-1:0]};
  assign busy_o     = busy_q;

  always_comb begin
    busy_d = busy_q;
    shr_d  = shr_q;
    if (emit) begin
      busy_d = (rest != '0);
      shr_d  = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shr_q <= shr_d;
  end

endmodule

`default_nettype wire

### rtl/uvc_decoder.sv
`default_nettype none

module uvc_decoder
  import uvc_pkg::*;
#(
  parameter int unsigned VW = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 take_i,
  input  wire logic [BYTE_BITS-1:0] byte_i,
  output dec_stat_t                 stat_o,
  output logic [VW-1:0]             value_o
);

  logic [VW-1:0]         acc_q, acc_d;
  logic [COUNT_W-1:0]    gc_q, gc_d;
  logic [6:0]            shift;
  logic [VW+6:0]         placed;
  logic [VW-1:0]         merged;
  logic                  ovf;
  logic                  done;

  assign shift  = 7'(gc_q) * 7'(GROUP_BITS);
  assign placed = (VW+7)'(byte_i[GROUP_BITS-1:0]) << shift;
  assign ovf    = (32'(shift) >= VW) || (placed[VW+6:VW] != '0);
  assign merged = acc_q | placed[VW-1:0];
  assign done   = !byte_i[BYTE_BITS-1];

  always_comb begin
    acc_d         = acc_q;
    gc_d          = gc_q;
    stat_o.fire   = 1'b0;
    stat_o.count  = '0;
    stat_o.status = ST_OK;
    value_o       = '0;
    if (take_i) begin
      if (ovf) begin
        acc_d         = '0;
        gc_d          = '0;
        stat_o.fire   = 1'b1;
        stat_o.status = ST_OVERFLOW;
      end else if (done) begin
        acc_d        = '0;
        gc_d         = '0;
        stat_o.fire  = 1'b1;
        stat_o.count = gc_q + 1'b1;
        value_o      = merged;
      end else begin
        acc_d = merged;
        gc_d  = gc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      gc_q  <= '0;
    end else begin
      acc_q <= acc_d;
      gc_q  <= gc_d;
    end
  end

endmodule

`default_nettype wire
